// ===== hw/rtl/qubit_state_vector_gate_engine_macros.svh =====
// Assertion macros shared by the gate engine RTL.
// Depends on nothing; the using module provides clk and rst.
`ifndef QUBIT_STATE_VECTOR_GATE_ENGINE_MACROS_SVH
`define QUBIT_STATE_VECTOR_GATE_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define QSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define QSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qsvge_pkg.sv =====
// Shared constants and types of the state-vector gate engine.
// Depends on nothing.
package qsvge_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int AMP_WIDTH  = 18;
  localparam int FRAC_BITS  = AMP_WIDTH - 2;

  // field widths
  localparam int REQ_W  = 3;
  localparam int TQ_W   = 4;
  localparam int RIDX_W = 10;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 4;

  // store geometry
  localparam int DEPTH   = 1 << MAX_QUBITS;
  localparam int ADDR_W  = MAX_QUBITS;
  localparam int ENTRY_W = 2 * AMP_WIDTH;
  localparam int NQ_W    = $clog2(MAX_QUBITS + 1);
  localparam int CMP_W   = (ADDR_W + 1 > RIDX_W) ? ADDR_W + 1 : RIDX_W;

  // arithmetic
  localparam int    SUM_W         = AMP_WIDTH + 1;
  localparam int    COEF_W        = FRAC_BITS + 2;
  localparam int    PROD_W        = SUM_W + COEF_W;
  localparam longint InvSqrt2Q32  = 64'd3037000500;
  localparam int    H_COEF        =
      int'((InvSqrt2Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam int    ROUND_HALF    = 1 << (FRAC_BITS - 1);
  localparam int    AMP_MAX       = (1 << (AMP_WIDTH - 1)) - 1;
  localparam int    AMP_MIN       = -(1 << (AMP_WIDTH - 1));
  localparam int    ONE_FIXED     = 1 << FRAC_BITS;
  localparam int    QC_RESET      = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_RESET    = 3'd0,
    REQ_HADAMARD = 3'd1,
    REQ_PAULI_X  = 3'd2,
    REQ_PAULI_Y  = 3'd3,
    REQ_PAULI_Z  = 3'd4,
    REQ_READ     = 3'd5
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE       = 2'd0,
    ST_BAD_TARGET = 2'd1,
    ST_BAD_INDEX  = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/qsvge_req_if.sv =====
// Request channel: valid/ready word carrying one engine request.
// Depends on qsvge_pkg.
interface qsvge_req_if;
  logic                           valid;
  logic                           ready;
  logic [qsvge_pkg::REQ_W-1:0]    req_type;
  logic [qsvge_pkg::TQ_W-1:0]     gate_target;
  logic [qsvge_pkg::RIDX_W-1:0]   read_index;

  modport source (output valid, req_type, gate_target, read_index, input ready);
  modport sink   (input valid, req_type, gate_target, read_index, output ready);
endinterface

// ===== hw/rtl/qsvge_res_if.sv =====
// Result channel: valid/ready word carrying one amplitude and status.
// Depends on qsvge_pkg.
interface qsvge_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qsvge_pkg::AMP_WIDTH-1:0] amp_real;
  logic signed [qsvge_pkg::AMP_WIDTH-1:0] amp_imag;
  logic [qsvge_pkg::ST_W-1:0]           status;

  modport source (output valid, amp_real, amp_imag, status, input ready);
  modport sink   (input valid, amp_real, amp_imag, status, output ready);
endinterface

// ===== hw/rtl/qsvge_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module qsvge_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/qubit_state_vector_gate_engine.sv =====
// Top level of the single-qubit gate engine over a complex state vector.
// Depends on qsvge_pkg, qsvge_req_if, qsvge_res_if, qsvge_ram and the macro header.
//
// The engine holds 2^MAX_QUBITS complex Q1.16 amplitudes in one RAM with a
// write port and a registered read port, and serves one request at a time;
// each request returns exactly one result word. A Hadamard, X, Y or Z gate
// streams the 2^n active amplitudes through the RAM read port, one read per
// cycle (both halves of a pair on consecutive cycles), and writes the two
// halves back from the write stages w and wj, after the sum stage s. A reset
// request clears all 2^MAX_QUBITS entries at one per cycle. After rst the
// same clearing pass runs, with no request accepted; num_qubits writes are
// taken at any time. The next request is accepted while a result word still
// waits at the output register.
`include "qubit_state_vector_gate_engine_macros.svh"

module qubit_state_vector_gate_engine (
  input  logic                        clk,
  input  logic                        rst,
  qsvge_req_if.sink                   req,
  qsvge_res_if.source                 res,
  input  logic                        cfg_we,
  input  logic [qsvge_pkg::CNT_W-1:0] cfg_wdata
);
  import qsvge_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_GATE,
    S_DRAIN,
    S_RDW,
    S_DONE
  } state_t;

  localparam logic [AMP_WIDTH-1:0] AmpMost  = {1'b1, {(AMP_WIDTH-1){1'b0}}};
  localparam logic [AMP_WIDTH-1:0] AmpTop   = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic signed [PROD_W:0] QMax   = (PROD_W+1)'(AMP_MAX);
  localparam logic signed [PROD_W:0] QMin   = (PROD_W+1)'(AMP_MIN);
  localparam logic [ADDR_W-1:0]    LastAddr = ADDR_W'(DEPTH - 1);

  // negate with saturation at the most negative code
  function automatic logic [AMP_WIDTH-1:0] neg_sat(input logic [AMP_WIDTH-1:0] x);
    logic [AMP_WIDTH-1:0] r;
    if (x == AmpMost) begin
      r = AmpTop;
    end else begin
      r = AMP_WIDTH'(-x);
    end
    return r;
  endfunction

  // multiply by 1/sqrt(2), round half up, saturate
  function automatic logic [AMP_WIDTH-1:0] hscale(input logic signed [SUM_W-1:0] s);
    logic signed [PROD_W:0] p;
    logic signed [PROD_W:0] q;
    logic [AMP_WIDTH-1:0]   r;
    p = $signed({{(PROD_W+1-SUM_W){s[SUM_W-1]}}, s}) * $signed((PROD_W+1)'(H_COEF))
        + $signed((PROD_W+1)'(ROUND_HALF));
    q = p >>> FRAC_BITS;
    if (q > QMax) begin
      r = AmpTop;
    end else if (q < QMin) begin
      r = AmpMost;
    end else begin
      r = q[AMP_WIDTH-1:0];
    end
    return r;
  endfunction

  // sign-extend an amplitude to sum width
  function automatic logic signed [SUM_W-1:0] sx(input logic [AMP_WIDTH-1:0] x);
    return $signed({x[AMP_WIDTH-1], x});
  endfunction

  // configuration register
  logic [CNT_W-1:0] num_qubits;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_qubits <= CNT_W'(QC_RESET);
    end else if (cfg_we) begin
      num_qubits <= cfg_wdata;
    end
  end

  // effective qubit count and vector size
  logic [NQ_W-1:0]   n_eff;
  logic [ADDR_W:0]   size;

  always_comb begin
    if (num_qubits == '0) begin
      n_eff = NQ_W'(1);
    end else if (int'(num_qubits) > MAX_QUBITS) begin
      n_eff = NQ_W'(MAX_QUBITS);
    end else begin
      n_eff = NQ_W'(num_qubits);
    end
    size = (ADDR_W+1)'(1) << n_eff;
  end

  // control registers
  state_t                state;
  logic [ADDR_W-1:0]     clr_cnt;
  logic                  clr_reply;
  logic [ADDR_W-1:0]     step;
  req_t                  op;
  logic [TQ_W-1:0]       tq;
  logic [AMP_WIDTH-1:0]  res_re;
  logic [AMP_WIDTH-1:0]  res_im;
  status_t               res_st;
  logic                  out_v;
  logic [AMP_WIDTH-1:0]  out_re;
  logic [AMP_WIDTH-1:0]  out_im;
  status_t               out_st;

  // pipeline registers
  logic                  d1_v;
  logic                  d1_ph;
  logic [ADDR_W-1:0]     d1_i;
  logic [ENTRY_W-1:0]    a0;
  logic                  s_v;
  logic [ADDR_W-1:0]     s_i;
  logic signed [SUM_W-1:0] s_r0, s_i0, s_r1, s_i1;
  req_t                  s_op;
  logic                  w_v;
  logic [ADDR_W-1:0]     w_i;
  logic [ENTRY_W-1:0]    w0, w1;
  logic                  wj_v;
  logic [ADDR_W-1:0]     wj_i;

  // RAM ports
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  // request decode
  logic                  accept;
  req_t                  in_op;
  logic                  bad_target;
  logic                  bad_index;
  logic                  read_go;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign in_op      = req_t'(req.req_type);
  assign bad_target = int'(req.gate_target) >= int'(n_eff);
  assign bad_index  = CMP_W'(req.read_index) >= CMP_W'(size);
  assign read_go    = accept && (in_op == REQ_READ) && !bad_index;

  // pair address: zero inserted at the target bit of the pair number
  logic [ADDR_W-1:0] tbit;
  logic [ADDR_W-1:0] lowmask;
  logic [ADDR_W-1:0] kk;
  logic [ADDR_W-1:0] addr_i;
  logic              iss;
  logic              last_step;

  assign tbit      = ADDR_W'(1) << tq;
  assign lowmask   = tbit - ADDR_W'(1);
  assign kk        = step >> 1;
  assign addr_i    = ((kk & ~lowmask) << 1) | (kk & lowmask);
  assign iss       = (state == S_GATE);
  assign last_step = (step == ADDR_W'(size - (ADDR_W+1)'(1)));

  // RAM port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = (clr_cnt == '0) ? {AMP_WIDTH'(ONE_FIXED), {AMP_WIDTH{1'b0}}} : '0;
    end else if (w_v) begin
      ram_we    = 1'b1;
      ram_waddr = w_i;
      ram_wdata = w0;
    end else if (wj_v) begin
      ram_we    = 1'b1;
      ram_waddr = wj_i | tbit;
      ram_wdata = w1;
    end
    ram_re    = iss || read_go;
    ram_raddr = iss ? (step[0] ? (addr_i | tbit) : addr_i) : ADDR_W'(req.read_index);
  end

  qsvge_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, result staging and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      out_v     <= 1'b0;
    end else begin
      // output word leaves; S_DONE reloads it in the same cycle
      if (out_v && res.ready && (state != S_DONE)) begin
        out_v <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_re <= '0;
            res_im <= '0;
            res_st <= ST_DONE;
            op     <= in_op;
            tq     <= req.gate_target;
            step   <= '0;
            case (in_op)
              REQ_RESET: begin
                clr_cnt   <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              REQ_HADAMARD, REQ_PAULI_X, REQ_PAULI_Y, REQ_PAULI_Z: begin
                if (bad_target) begin
                  res_st <= ST_BAD_TARGET;
                  state  <= S_DONE;
                end else begin
                  state  <= S_GATE;
                end
              end
              REQ_READ: begin
                if (bad_index) begin
                  res_st <= ST_BAD_INDEX;
                  state  <= S_DONE;
                end else begin
                  state  <= S_RDW;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == LastAddr) begin
            clr_reply <= 1'b0;
            state     <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_GATE: begin
          step <= step + ADDR_W'(1);
          if (last_step) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!d1_v && !s_v && !w_v && !wj_v) begin
            state <= S_DONE;
          end
        end
        S_RDW: begin
          res_re <= ram_rdata[ENTRY_W-1:AMP_WIDTH];
          res_im <= ram_rdata[AMP_WIDTH-1:0];
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_v || res.ready) begin
            out_v  <= 1'b1;
            out_re <= res_re;
            out_im <= res_im;
            out_st <= res_st;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid    = out_v;
  assign res.amp_real = $signed(out_re);
  assign res.amp_imag = $signed(out_im);
  assign res.status   = out_st;

  // read-modify-write pipeline: capture a0, combine with a1, scale, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
      s_v  <= 1'b0;
      w_v  <= 1'b0;
      wj_v <= 1'b0;
    end else begin
      d1_v <= iss;
      s_v  <= d1_v && d1_ph;
      w_v  <= s_v;
      wj_v <= w_v;
    end
    d1_ph <= step[0];
    d1_i  <= addr_i;

    if (d1_v && !d1_ph) begin
      a0 <= ram_rdata;
    end

    // stage s: sums for Hadamard, final values for the Pauli gates
    if (d1_v && d1_ph) begin
      s_i  <= d1_i;
      s_op <= op;
      case (op)
        REQ_HADAMARD: begin
          s_r0 <= sx(a0[ENTRY_W-1:AMP_WIDTH]) + sx(ram_rdata[ENTRY_W-1:AMP_WIDTH]);
          s_i0 <= sx(a0[AMP_WIDTH-1:0]) + sx(ram_rdata[AMP_WIDTH-1:0]);
          s_r1 <= sx(a0[ENTRY_W-1:AMP_WIDTH]) - sx(ram_rdata[ENTRY_W-1:AMP_WIDTH]);
          s_i1 <= sx(a0[AMP_WIDTH-1:0]) - sx(ram_rdata[AMP_WIDTH-1:0]);
        end
        REQ_PAULI_X: begin
          s_r0 <= sx(ram_rdata[ENTRY_W-1:AMP_WIDTH]);
          s_i0 <= sx(ram_rdata[AMP_WIDTH-1:0]);
          s_r1 <= sx(a0[ENTRY_W-1:AMP_WIDTH]);
          s_i1 <= sx(a0[AMP_WIDTH-1:0]);
        end
        REQ_PAULI_Y: begin
          s_r0 <= sx(ram_rdata[AMP_WIDTH-1:0]);
          s_i0 <= sx(neg_sat(ram_rdata[ENTRY_W-1:AMP_WIDTH]));
          s_r1 <= sx(neg_sat(a0[AMP_WIDTH-1:0]));
          s_i1 <= sx(a0[ENTRY_W-1:AMP_WIDTH]);
        end
        default: begin
          s_r0 <= sx(a0[ENTRY_W-1:AMP_WIDTH]);
          s_i0 <= sx(a0[AMP_WIDTH-1:0]);
          s_r1 <= sx(neg_sat(ram_rdata[ENTRY_W-1:AMP_WIDTH]));
          s_i1 <= sx(neg_sat(ram_rdata[AMP_WIDTH-1:0]));
        end
      endcase
    end

    // stage w: Hadamard scaling, others pass through
    if (s_v) begin
      w_i <= s_i;
      if (s_op == REQ_HADAMARD) begin
        w0 <= {hscale(s_r0), hscale(s_i0)};
        w1 <= {hscale(s_r1), hscale(s_i1)};
      end else begin
        w0 <= {s_r0[AMP_WIDTH-1:0], s_i0[AMP_WIDTH-1:0]};
        w1 <= {s_r1[AMP_WIDTH-1:0], s_i1[AMP_WIDTH-1:0]};
      end
    end
    wj_i <= w_i;
  end

  // pairs are disjoint, so a write never lands on the entry being read
  `QSV_ASSERT_IMP(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr, "read/write same entry")
  // second write of a pair goes to the entry with the target bit set
  `QSV_ASSERT_IMP(a_upper_write, wj_v, (ram_waddr & tbit) != '0, "upper write missing target bit")
  // non-done status carries zero amplitude
  `QSV_ASSERT_IMP(a_err_zero, res.valid && (res.status != ST_DONE), (res.amp_real == '0) && (res.amp_imag == '0), "error word with data")
  // pipeline is empty whenever a new request may enter
  `QSV_ASSERT_IMP(a_idle_empty, state == S_IDLE, !d1_v && !s_v && !w_v && !wj_v, "pipeline busy at idle")
  // a gate read leaves the pipeline stage busy in the next cycle
  `QSV_ASSERT_NXT(a_issue_track, iss, d1_v, "issued read not tracked")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the single-qubit gate engine over a state vector.
// Depends on qsvge_pkg, qsvge_req_if, qsvge_res_if and the engine top level.
// A scoreboard mirrors the amplitude store and checks every result word in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qsvge_pkg::*;

  localparam int       CYCLE_LIMIT = 5_000_000;
  localparam int       PRINT_CAP   = 100;
  localparam longint   H_FACTOR    =
      (64'd3037000500 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam longint   AMP_TOP     = (64'sd1 <<< (AMP_WIDTH - 1)) - 1;
  localparam longint   AMP_BOTTOM  = -(64'sd1 <<< (AMP_WIDTH - 1));

  typedef struct {
    logic signed [AMP_WIDTH-1:0] re;
    logic signed [AMP_WIDTH-1:0] im;
    logic [ST_W-1:0]             st;
  } amp_word_t;

  // Mirror of the amplitude store plus the queue of result words still owed
  class amp_scoreboard;
    int          vec_re [DEPTH];
    int          vec_im [DEPTH];
    int          qubit_setting;
    amp_word_t   awaited_words [$];
    int          mismatches;
    int          requests;
    int          checked;

    function new();
      clear_vector();
      qubit_setting = QC_RESET;
      mismatches    = 0;
      requests      = 0;
      checked       = 0;
    endfunction

    function void clear_vector();
      foreach (vec_re[k]) begin
        vec_re[k] = 0;
        vec_im[k] = 0;
      end
      vec_re[0] = ONE_FIXED;
    endfunction

    function int active_qubits();
      if (qubit_setting < 1) return 1;
      if (qubit_setting > MAX_QUBITS) return MAX_QUBITS;
      return qubit_setting;
    endfunction

    function int clip(longint x);
      if (x > AMP_TOP) return int'(AMP_TOP);
      if (x < AMP_BOTTOM) return int'(AMP_BOTTOM);
      return int'(x);
    endfunction

    // scale by 1/sqrt(2): round to nearest, ties up, then saturate
    function int h_scale(int s);
      longint p;
      p = longint'(s) * H_FACTOR + (longint'(ONE_FIXED) >>> 1);
      return clip(p >>> FRAC_BITS);
    endfunction

    // apply one accepted request to the mirror and queue its result word
    function void note_request(logic [REQ_W-1:0] rt, logic [TQ_W-1:0] tq,
                               logic [RIDX_W-1:0] ri);
      amp_word_t w;
      int        n;
      int        size;
      int        bit_m;
      int        i;
      int        j;
      int        r0, i0, r1, i1;
      n     = active_qubits();
      size  = 1 << n;
      w.re  = '0;
      w.im  = '0;
      w.st  = ST_DONE;
      requests++;
      case (rt)
        REQ_RESET: clear_vector();
        REQ_HADAMARD, REQ_PAULI_X, REQ_PAULI_Y, REQ_PAULI_Z: begin
          if (int'(tq) >= n) begin
            w.st = ST_BAD_TARGET;
          end else begin
            bit_m = 1 << tq;
            for (i = 0; i < size; i++) begin
              if ((i & bit_m) != 0) continue;
              j  = i | bit_m;
              r0 = vec_re[i]; i0 = vec_im[i];
              r1 = vec_re[j]; i1 = vec_im[j];
              case (rt)
                REQ_HADAMARD: begin
                  vec_re[i] = h_scale(r0 + r1);
                  vec_im[i] = h_scale(i0 + i1);
                  vec_re[j] = h_scale(r0 - r1);
                  vec_im[j] = h_scale(i0 - i1);
                end
                REQ_PAULI_X: begin
                  vec_re[i] = r1; vec_im[i] = i1;
                  vec_re[j] = r0; vec_im[j] = i0;
                end
                REQ_PAULI_Y: begin
                  // a0' = -i*a1, a1' = i*a0, both from the old pair
                  vec_re[i] = i1;
                  vec_im[i] = clip(-longint'(r1));
                  vec_re[j] = clip(-longint'(i0));
                  vec_im[j] = r0;
                end
                default: begin
                  vec_re[j] = clip(-longint'(r1));
                  vec_im[j] = clip(-longint'(i1));
                end
              endcase
            end
          end
        end
        REQ_READ: begin
          if (int'(ri) >= size) begin
            w.st = ST_BAD_INDEX;
          end else begin
            w.re = AMP_WIDTH'(vec_re[ri]);
            w.im = AMP_WIDTH'(vec_im[ri]);
          end
        end
        default: ;  // unused codes: no effect, status done
      endcase
      awaited_words.push_back(w);
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    // compare one accepted result word against the oldest one owed
    task check_word(logic signed [AMP_WIDTH-1:0] re, logic signed [AMP_WIDTH-1:0] im,
                    logic [ST_W-1:0] st);
      amp_word_t w;
      if (awaited_words.size() == 0) begin
        report_mismatch("result word with no request outstanding");
        return;
      end
      w = awaited_words.pop_front();
      checked++;
      if (st !== w.st)
        report_mismatch($sformatf("word %0d status %0d, want %0d", checked, st, w.st));
      if (re !== w.re)
        report_mismatch($sformatf("word %0d amp_real %0d, want %0d", checked, re, w.re));
      if (im !== w.im)
        report_mismatch($sformatf("word %0d amp_imag %0d, want %0d", checked, im, w.im));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_wdata;
  int                 cycles;
  int                 settings_used;
  bit                 calm_phase;
  amp_scoreboard      sb;

  qsvge_req_if req_if ();
  qsvge_res_if res_if ();

  qubit_state_vector_gate_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one request word; valid stays high after the accept edge
  task automatic send_req(logic [REQ_W-1:0] rt, logic [TQ_W-1:0] tq,
                          logic [RIDX_W-1:0] ri);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= rt;
    req_if.gate_target  <= tq;
    req_if.read_index   <= ri;
    do @(posedge clk); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
    sb.note_request(rt, tq, ri);
  endtask

  // drain the engine's owed result words, then write num_qubits
  task automatic set_num_qubits(int v);
    req_if.valid <= 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.qubit_setting = v;
    settings_used++;
  endtask

  // random request, mostly well formed for the current vector size
  task automatic send_random(int n);
    int                 pick;
    logic [REQ_W-1:0]   rt;
    logic [TQ_W-1:0]    tq;
    logic [RIDX_W-1:0]  ri;
    pick = $urandom_range(0, 99);
    tq   = TQ_W'($urandom_range(0, 15));
    ri   = RIDX_W'($urandom_range(0, 1023));
    if (pick < 2) begin
      rt = REQ_RESET;
    end else if (pick < 60) begin
      rt = REQ_W'($urandom_range(REQ_HADAMARD, REQ_PAULI_Z));
      if ($urandom_range(0, 9) != 0) tq = TQ_W'($urandom_range(0, n - 1));
    end else if (pick < 94) begin
      rt = REQ_READ;
      if ($urandom_range(0, 6) != 0) ri = RIDX_W'($urandom_range(0, (1 << n) - 1));
    end else begin
      rt = REQ_W'($urandom_range(REQ_READ + 1, 7));
    end
    send_req(rt, tq, ri);
  endtask

  // result side: random stall before each word, checks at the accept edge
  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = calm_phase ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
      sb.check_word(res_if.amp_real, res_if.amp_imag, res_if.status);
    end
  end

  // main sequence
  initial begin : stimulus
    int phase_counts [14];
    int items;
    int n;
    phase_counts = '{3, 1, 0, 5, 2, 4, 15, 6, 10, 2, 7, 3, 12, 4};
    sb            = new();
    cycles        = 0;
    settings_used = 0;
    calm_phase    = 1'b0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= '0;
    req_if.gate_target  <= '0;
    req_if.read_index   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: two qubits, each gate, reads at the edges, bad fields, reset
    set_num_qubits(2);
    send_req(REQ_READ, 4'd0, 10'd0);
    send_req(REQ_READ, 4'd15, 10'd3);
    send_req(REQ_READ, 4'd0, 10'd4);
    send_req(REQ_READ, 4'd0, 10'd1023);
    send_req(REQ_HADAMARD, 4'd0, 10'd1023);
    send_req(REQ_HADAMARD, 4'd1, 10'd0);
    for (int k = 0; k < 4; k++) send_req(REQ_READ, 4'd0, RIDX_W'(k));
    send_req(REQ_PAULI_X, 4'd1, 10'd0);
    send_req(REQ_PAULI_Y, 4'd0, 10'd0);
    send_req(REQ_PAULI_Z, 4'd1, 10'd0);
    send_req(REQ_PAULI_Z, 4'd0, 10'd0);
    for (int k = 0; k < 4; k++) send_req(REQ_READ, 4'd0, RIDX_W'(k));
    // target beyond the active qubits leaves the vector alone
    send_req(REQ_HADAMARD, 4'd2, 10'd0);
    send_req(REQ_PAULI_X, 4'd15, 10'd1023);
    // unused codes just report done
    send_req(REQ_W'(6), 4'd15, 10'd1023);
    send_req(REQ_W'(7), 4'd0, 10'd0);
    send_req(REQ_RESET, 4'd15, 10'd1023);
    send_req(REQ_READ, 4'd0, 10'd0);

    // random phases over a spread of sizes; large vectors get fewer items
    foreach (phase_counts[p]) begin
      set_num_qubits(phase_counts[p]);
      n          = sb.active_qubits();
      items      = (n <= 6) ? 40 : 12;
      calm_phase = ($urandom_range(0, 3) == 0);
      repeat (items) send_random(n);
    end

    // drain and let any stray word show up
    req_if.valid <= 1'b0;
    calm_phase   = 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.awaited_words.size() != 0) sb.report_mismatch("result words never arrived");

    $display("Sent %0d requests, checked %0d result words, %0d register settings.",
             sb.requests, sb.checked, settings_used);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qsvge_pkg.sv
hw/rtl/qsvge_req_if.sv
hw/rtl/qsvge_res_if.sv
hw/rtl/qsvge_ram.sv
hw/rtl/qubit_state_vector_gate_engine.sv
verif/tb_top.sv
